FILE: hw/rtl/sdm_pkg.sv
// ----------------------------------------------------------------------------
// sdm_pkg
// Shared sizes, command codes and state type of the suffix dictionary matcher.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sdm_pkg;

    localparam int WINDOW_LEN = 16;
    localparam int MAX_WORDS  = 512;
    localparam int KEEP_TAIL  = 2;

    // fixed field widths
    localparam int CMD_W   = 3;
    localparam int CHAR_W  = 8;
    localparam int IDX_W   = 9;
    localparam int POSF_W  = 4;
    localparam int LEN_W   = 5;
    localparam int CFG_W   = 10;
    localparam int HELD_W  = 5;

    // derived sizes
    localparam int WIN_AW   = $clog2(WINDOW_LEN);
    localparam int COUNT_W  = $clog2(WINDOW_LEN + 1);
    localparam int WORD_AW  = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
    localparam int CHAR_DEPTH = MAX_WORDS * WINDOW_LEN;
    localparam int CHAR_AW  = $clog2(CHAR_DEPTH);

    typedef logic [CMD_W-1:0] cmd_t;

    localparam cmd_t CMD_APPEND   = 3'd0;
    localparam cmd_t CMD_CHECK    = 3'd1;
    localparam cmd_t CMD_CLEAR    = 3'd2;
    localparam cmd_t CMD_WR_CHAR  = 3'd3;
    localparam cmd_t CMD_SET_LEN  = 3'd4;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_LEN  = 4'b0010,
        ST_CHR  = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

endpackage

`default_nettype wire

FILE: hw/rtl/sdm_ram.sv
// ----------------------------------------------------------------------------
// sdm_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sdm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: hw/rtl/suffix_dictionary_matcher.sv
// ----------------------------------------------------------------------------
// suffix_dictionary_matcher
// Sliding letter window checked against a stored dictionary of word suffixes.
// ----------------------------------------------------------------------------
// Usage:
// Items come in on the item channel (cmd, letter, word_index, char_pos,
// word_length) with item_valid/item_ready; every item gives exactly one result
// (match_found, match_index, letters_held) on the result channel with
// result_valid/result_ready. dict_count is written through cfg_write_en and
// cfg_write_data; the user must write it only while the block is idle, and
// the block itself does not enforce this. Append, clear, write char, set
// length and unused commands go from ST_IDLE to ST_DONE and from there to the
// output register. A check scans the entries in order with one shared
// compare unit fed by the registered read ports of the two dictionary RAMs:
// for each entry ST_LEN reads its length, then ST_CHR compares its characters
// one by one; a check scans at most MAX_WORDS entries.
// One item is in work at a time; item_ready is low until the result has
// moved to the output register. A stalled receiver holds the result there;
// the next item is still taken and worked on, but its result waits until
// the held one is gone.
// Reset empties the window and sets dict_count to zero; dictionary contents
// are not cleared and must be written before they are checked.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module suffix_dictionary_matcher (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_write_en,
    input  wire logic [sdm_pkg::CFG_W-1:0]  cfg_write_data,
    input  wire logic                       item_valid,
    output logic                            item_ready,
    input  wire logic [sdm_pkg::CMD_W-1:0]  cmd,
    input  wire logic [sdm_pkg::CHAR_W-1:0] letter,
    input  wire logic [sdm_pkg::IDX_W-1:0]  word_index,
    input  wire logic [sdm_pkg::POSF_W-1:0] char_pos,
    input  wire logic [sdm_pkg::LEN_W-1:0]  word_length,
    output logic                            result_valid,
    input  wire logic                       result_ready,
    output logic                            match_found,
    output logic [sdm_pkg::IDX_W-1:0]       match_index,
    output logic [sdm_pkg::HELD_W-1:0]      letters_held
);

    localparam int W = sdm_pkg::WINDOW_LEN;

    sdm_pkg::state_t state_reg, state_next;

    logic [sdm_pkg::COUNT_W-1:0] count_reg, count_next;
    logic [sdm_pkg::CFG_W-1:0]   dict_count_reg;
    logic [sdm_pkg::CHAR_W-1:0]  win_reg [W];
    logic [sdm_pkg::CHAR_W-1:0]  win_next [W];

    logic [sdm_pkg::WORD_AW-1:0] entry_reg, entry_next;
    logic [sdm_pkg::WORD_AW-1:0] last_reg, last_next;
    logic [sdm_pkg::LEN_W-1:0]   len_reg, len_next;
    logic [sdm_pkg::WIN_AW-1:0]  pos_reg, pos_next;
    logic                        found_reg, found_next;
    logic [sdm_pkg::WORD_AW-1:0] fidx_reg, fidx_next;

    logic                        out_valid_reg, out_valid_next;
    logic                        out_found_reg, out_found_next;
    logic [sdm_pkg::IDX_W-1:0]   out_idx_reg, out_idx_next;
    logic [sdm_pkg::HELD_W-1:0]  out_held_reg, out_held_next;

    // dictionary RAM ports
    logic                        len_we, chr_we;
    logic [sdm_pkg::WORD_AW-1:0] len_waddr, len_raddr;
    logic [sdm_pkg::CHAR_AW-1:0] chr_waddr, chr_raddr;
    logic [sdm_pkg::LEN_W-1:0]   len_rdata;
    logic [sdm_pkg::CHAR_W-1:0]  chr_rdata;

    logic                        idx_ok, pos_ok;
    logic [sdm_pkg::WIN_AW-1:0]  win_idx;
    logic [31:0]                 limit;

    sdm_ram #(
        .WIDTH (sdm_pkg::LEN_W),
        .DEPTH (sdm_pkg::MAX_WORDS)
    ) u_len_ram (
        .clk   (clk),
        .we    (len_we),
        .waddr (len_waddr),
        .wdata (word_length),
        .raddr (len_raddr),
        .rdata (len_rdata)
    );

    sdm_ram #(
        .WIDTH (sdm_pkg::CHAR_W),
        .DEPTH (sdm_pkg::CHAR_DEPTH)
    ) u_chr_ram (
        .clk   (clk),
        .we    (chr_we),
        .waddr (chr_waddr),
        .wdata (letter),
        .raddr (chr_raddr),
        .rdata (chr_rdata)
    );

    assign idx_ok    = 32'(word_index) < 32'(sdm_pkg::MAX_WORDS);
    assign pos_ok    = 32'(char_pos) < 32'(W);
    assign len_waddr = sdm_pkg::WORD_AW'(word_index);
    assign chr_waddr = sdm_pkg::CHAR_AW'(32'(word_index) * 32'(W) + 32'(char_pos));
    assign limit     = (32'(dict_count_reg) > 32'(sdm_pkg::MAX_WORDS))
                       ? 32'(sdm_pkg::MAX_WORDS) : 32'(dict_count_reg);

    // window is right aligned: newest letter in the top slot
    assign win_idx = sdm_pkg::WIN_AW'(32'(W) - 32'(len_reg) + 32'(pos_reg));

    // read addresses follow the next values so data is there in the next cycle
    assign len_raddr = entry_next;
    assign chr_raddr = sdm_pkg::CHAR_AW'(32'(entry_next) * 32'(W) + 32'(pos_next));

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        win_next       = win_reg;
        entry_next     = entry_reg;
        last_next      = last_reg;
        len_next       = len_reg;
        pos_next       = pos_reg;
        found_next     = found_reg;
        fidx_next      = fidx_reg;
        out_valid_next = out_valid_reg;
        out_found_next = out_found_reg;
        out_idx_next   = out_idx_reg;
        out_held_next  = out_held_reg;
        len_we         = 1'b0;
        chr_we         = 1'b0;
        item_ready     = (state_reg == sdm_pkg::ST_IDLE);

        if (out_valid_reg && result_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            sdm_pkg::ST_IDLE:
            begin
                if (item_valid)
                begin
                    found_next = 1'b0;
                    fidx_next  = '0;
                    state_next = sdm_pkg::ST_DONE;
                    case (cmd)
                        sdm_pkg::CMD_APPEND:
                        begin
                            for (int k = 0; k < W - 1; k++)
                            begin
                                win_next[k] = win_reg[k+1];
                            end
                            win_next[W-1] = letter;
                            if (32'(count_reg) < 32'(W))
                            begin
                                count_next = count_reg + 1'b1;
                            end
                        end
                        sdm_pkg::CMD_CHECK:
                        begin
                            if (count_reg != '0 && limit != 32'd0)
                            begin
                                entry_next = '0;
                                last_next  = sdm_pkg::WORD_AW'(limit - 32'd1);
                                state_next = sdm_pkg::ST_LEN;
                            end
                        end
                        sdm_pkg::CMD_CLEAR:
                        begin
                            count_next = '0;
                        end
                        sdm_pkg::CMD_WR_CHAR:
                        begin
                            chr_we = idx_ok && pos_ok;
                        end
                        sdm_pkg::CMD_SET_LEN:
                        begin
                            len_we = idx_ok;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            sdm_pkg::ST_LEN:
            begin
                len_next = len_rdata;
                if (32'(len_rdata) > 32'(count_reg))
                begin
                    // word longer than window contents: skip entry
                    if (entry_reg == last_reg)
                    begin
                        state_next = sdm_pkg::ST_DONE;
                    end
                    else
                    begin
                        entry_next = entry_reg + 1'b1;
                    end
                end
                else if (len_rdata == '0)
                begin
                    found_next = 1'b1;
                    fidx_next  = entry_reg;
                    count_next = (32'(count_reg) > 32'(sdm_pkg::KEEP_TAIL))
                                 ? sdm_pkg::COUNT_W'(sdm_pkg::KEEP_TAIL) : count_reg;
                    state_next = sdm_pkg::ST_DONE;
                end
                else
                begin
                    pos_next   = '0;
                    state_next = sdm_pkg::ST_CHR;
                end
            end

            sdm_pkg::ST_CHR:
            begin
                if (chr_rdata != win_reg[win_idx])
                begin
                    if (entry_reg == last_reg)
                    begin
                        state_next = sdm_pkg::ST_DONE;
                    end
                    else
                    begin
                        entry_next = entry_reg + 1'b1;
                        state_next = sdm_pkg::ST_LEN;
                    end
                end
                else if (32'(pos_reg) + 32'd1 == 32'(len_reg))
                begin
                    // tail kept in place, only the count shrinks
                    found_next = 1'b1;
                    fidx_next  = entry_reg;
                    count_next = (32'(count_reg) > 32'(sdm_pkg::KEEP_TAIL))
                                 ? sdm_pkg::COUNT_W'(sdm_pkg::KEEP_TAIL) : count_reg;
                    state_next = sdm_pkg::ST_DONE;
                end
                else
                begin
                    pos_next = pos_reg + 1'b1;
                end
            end

            sdm_pkg::ST_DONE:
            begin
                if (!out_valid_reg || result_ready)
                begin
                    out_valid_next = 1'b1;
                    out_found_next = found_reg;
                    out_idx_next   = sdm_pkg::IDX_W'(fidx_reg);
                    out_held_next  = sdm_pkg::HELD_W'(count_reg);
                    state_next     = sdm_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = sdm_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= sdm_pkg::ST_IDLE;
            count_reg      <= '0;
            dict_count_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write_en)
            begin
                dict_count_reg <= cfg_write_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg       <= win_next;
        entry_reg     <= entry_next;
        last_reg      <= last_next;
        len_reg       <= len_next;
        pos_reg       <= pos_next;
        found_reg     <= found_next;
        fidx_reg      <= fidx_next;
        out_found_reg <= out_found_next;
        out_idx_reg   <= out_idx_next;
        out_held_reg  <= out_held_next;
    end

    assign result_valid = out_valid_reg;
    assign match_found  = out_found_reg;
    assign match_index  = out_idx_reg;
    assign letters_held = out_held_reg;

    // window never holds more than its length
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= 32'(W))
        else $error("letter count beyond window length");

    // a match leaves one or two letters in the window
    a_match_tail: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && match_found) |->
            (letters_held != '0 && 32'(letters_held) <= 32'(sdm_pkg::KEEP_TAIL)))
        else $error("match result with wrong letter count");

    // no match reports index zero
    a_nomatch_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !match_found) |-> (match_index == '0))
        else $error("index reported without a match");

    // scan never runs past the last entry
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sdm_pkg::ST_LEN || state_reg == sdm_pkg::ST_CHR) |->
            (entry_reg <= last_reg))
        else $error("scan beyond dictionary count");

endmodule

`default_nettype wire
